@@ design/rij_pkg.sv @@
// Shared widths, codes and constants of the RTP interarrival jitter block.
package rij_pkg;

    // Field widths
    localparam int SEQ_W      = 32;
    localparam int TS_W       = 32;
    localparam int US_W       = 40;
    localparam int UNITS_W    = 40;
    localparam int STATUS_W   = 3;
    localparam int JIT_W      = 36;
    localparam int ABS_W      = 32;
    localparam int RATE_W     = 18;
    localparam int WARM_W     = 8;
    localparam int CNT_W      = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 18;

    // Arrival conversion: us * rate / 10^6 = ((us * rate) >> 6) / 15625
    localparam int PROD_W     = US_W + RATE_W;
    localparam int US_SHIFT   = 6;
    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = (PROD_W - US_SHIFT + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_NUM_W  = DIV_STAGES * DIV_STEPS;
    localparam int DIV_REM_W  = 14;
    localparam logic [DIV_REM_W:0] DIV_ODD = 15'd15625;

    // Signed transit difference width
    localparam int D_W = UNITS_W + 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_FIRST   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RESYNC  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_STALE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SAME_TS = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WARMUP  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_JITTER  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_RATE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP     = 4'd1;

    // Reset values and limits
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd8000;
    localparam logic [WARM_W-1:0] WARM_RESET = 8'd5;
    localparam logic [CNT_W-1:0]  COUNT_MAX  = 9'd511;

    // Sequence and timestamp of one packet, carried alongside the divider
    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
    } rij_pkt_t;

endpackage

@@ design/rij_if.sv @@
// Channel interfaces: packet input, result output and configuration write.
interface rij_in_if;
    logic                       valid;
    logic                       ready;
    logic [rij_pkg::SEQ_W-1:0]  ext_seq;
    logic [rij_pkg::TS_W-1:0]   rtp_timestamp;
    logic [rij_pkg::US_W-1:0]   arrival_us;

    modport source (output valid, ext_seq, rtp_timestamp, arrival_us, input ready);
    modport sink   (input valid, ext_seq, rtp_timestamp, arrival_us, output ready);
endinterface

interface rij_out_if;
    logic                         valid;
    logic                         ready;
    logic [rij_pkg::STATUS_W-1:0] status;
    logic [rij_pkg::JIT_W-1:0]    jitter_q4;
    logic [rij_pkg::ABS_W-1:0]    abs_delta;
    logic [rij_pkg::ABS_W-1:0]    max_abs_delta;

    modport source (output valid, status, jitter_q4, abs_delta, max_abs_delta, input ready);
    modport sink   (input valid, status, jitter_q4, abs_delta, max_abs_delta, output ready);
endinterface

interface rij_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rij_pkg::CFG_IDX_W-1:0]  index;
    logic [rij_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/rij_unit_div.sv @@
// Pipelined restoring divider by 15625, several quotient bits per stage.
module rij_unit_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_vld,
    output logic                            in_rdy,
    input  logic [rij_pkg::DIV_NUM_W-1:0]   in_num,
    input  rij_pkg::rij_pkt_t               in_tag,
    output logic                            out_vld,
    input  logic                            out_rdy,
    output logic [rij_pkg::UNITS_W-1:0]     out_quot,
    output rij_pkg::rij_pkt_t               out_tag
);

    localparam int NST = rij_pkg::DIV_STAGES;
    localparam int NW  = rij_pkg::DIV_NUM_W;
    localparam int RW  = rij_pkg::DIV_REM_W;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [NW-1:0] num;
    } div_st_t;

    logic              vld_reg [NST];
    div_st_t           st_reg  [NST];
    rij_pkg::rij_pkt_t tag_reg [NST];

    div_st_t st_next  [NST];
    logic    stg_rdy  [NST];

    // Shift one dividend bit into the remainder per step; quotient fills num
    function automatic div_st_t div_steps(div_st_t st);
        logic [RW:0] part;
        div_st_t     r;
        r = st;
        for (int i = 0; i < rij_pkg::DIV_STEPS; i++) begin
            part  = {r.rem, r.num[NW-1]};
            r.num = {r.num[NW-2:0], 1'b0};
            if (part >= rij_pkg::DIV_ODD) begin
                part     = part - rij_pkg::DIV_ODD;
                r.num[0] = 1'b1;
            end
            r.rem = part[RW-1:0];
        end
        return r;
    endfunction

    // Work out each stage's next word
    always_comb
    begin
        for (int s = 0; s < NST; s++) begin
            if (s == 0)
                st_next[s] = div_steps('{rem: '0, num: in_num});
            else
                st_next[s] = div_steps(st_reg[s-1]);
        end
    end

    // Stage can take a word when empty or when its own word moves on
    always_comb
    begin
        for (int s = NST - 1; s >= 0; s--) begin
            if (s == NST - 1)
                stg_rdy[s] = !vld_reg[s] || out_rdy;
            else
                stg_rdy[s] = !vld_reg[s] || stg_rdy[s+1];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int s = 0; s < NST; s++)
                vld_reg[s] <= 1'b0;
        end else begin
            for (int s = 0; s < NST; s++) begin
                if (stg_rdy[s])
                    vld_reg[s] <= (s == 0) ? in_vld : vld_reg[s-1];
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NST; s++) begin
            if (stg_rdy[s]) begin
                st_reg[s]  <= st_next[s];
                tag_reg[s] <= (s == 0) ? in_tag : tag_reg[s-1];
            end
        end
    end

    assign in_rdy   = stg_rdy[0];
    assign out_vld  = vld_reg[NST-1];
    assign out_quot = st_reg[NST-1].num[rij_pkg::UNITS_W-1:0];
    assign out_tag  = tag_reg[NST-1];

endmodule

@@ design/rtp_interarrival_jitter_top.sv @@
// Top level of the RTP interarrival jitter estimator.
//
// Channels: pkt takes one received packet per word (extended sequence,
// RTP timestamp, arrival time in microseconds); res gives one result word
// per packet (status, jitter in timestamp units with four fraction bits,
// saturated |D| of the packet, running maximum |D|); cfg writes clock_rate
// (index 0) and warmup_packets (index 1) and is always ready; the user must
// write it only while no packet is in flight, the block does not enforce it.
// Path of a packet: input register, rate multiply, seven divider stages
// of eight quotient bits each, reference update, magnitude, jitter update.
// Throughput: one packet per cycle while res is not stalled; every stage
// is a register with a valid bit, so a word can enter each cycle, the
// divide by 10^6 being pipelined.
// Reset clears all references, the jitter and the maximum, and loads
// clock_rate 8000 and warmup_packets 5.
// When res is stalled the result holds in the output register; stages
// behind it keep filling bubbles and pkt.ready drops only once all
// stages hold a word.
module rtp_interarrival_jitter_top (
    input  logic     clk,
    input  logic     rst_n,
    rij_in_if.sink   pkt,
    rij_out_if.source res,
    rij_cfg_if.sink  cfg
);

    // Configuration registers
    logic [rij_pkg::RATE_W-1:0] rate_reg;
    logic [rij_pkg::WARM_W-1:0] warm_reg;

    // Input stage
    logic                      i_vld_reg;
    rij_pkg::rij_pkt_t         i_tag_reg;
    logic [rij_pkg::US_W-1:0]  i_us_reg;
    logic                      i_rdy;

    // Product stage
    logic                        p_vld_reg;
    rij_pkg::rij_pkt_t           p_tag_reg;
    logic [rij_pkg::PROD_W-1:0]  p_prod_reg;
    logic [rij_pkg::PROD_W-1:0]  p_prod_next;
    logic                        p_rdy;

    // Divider
    logic                          div_in_rdy;
    logic                          div_out_vld;
    logic [rij_pkg::UNITS_W-1:0]   div_units;
    rij_pkg::rij_pkt_t             div_tag;
    logic [rij_pkg::DIV_NUM_W-1:0] div_num;

    // Reference state
    logic                         started_reg,   started_next;
    logic [rij_pkg::SEQ_W-1:0]    ref_seq_reg,   ref_seq_next;
    logic [rij_pkg::TS_W-1:0]     ref_ts_reg,    ref_ts_next;
    logic [rij_pkg::UNITS_W-1:0]  ref_units_reg, ref_units_next;
    logic [rij_pkg::CNT_W-1:0]    count_reg,     count_next;

    // Evaluate stage
    logic                          e_vld_reg;
    logic [rij_pkg::STATUS_W-1:0]  e_status_reg, e_status_next;
    logic [rij_pkg::D_W-1:0]       e_d_reg,      e_d_next;
    logic                          e_rdy;
    logic                          e_ld;

    // Magnitude stage
    logic                          f_vld_reg;
    logic [rij_pkg::STATUS_W-1:0]  f_status_reg;
    logic [rij_pkg::ABS_W-1:0]     f_abs_reg,    f_abs_next;
    logic                          f_rdy;

    // Jitter state and output register
    logic [rij_pkg::JIT_W-1:0]     jitter_reg,   jitter_next;
    logic [rij_pkg::ABS_W-1:0]     max_reg,      max_next;
    logic                          res_vld_reg;
    logic [rij_pkg::STATUS_W-1:0]  res_status_reg;
    logic [rij_pkg::ABS_W-1:0]     res_abs_reg;
    logic                          g_rdy;
    logic                          g_ld;

    // Hold configuration; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rate_reg <= rij_pkg::RATE_RESET;
            warm_reg <= rij_pkg::WARM_RESET;
        end else if (cfg.valid) begin
            case (cfg.index)
                rij_pkg::CFG_CLOCK_RATE: rate_reg <= cfg.data[rij_pkg::RATE_W-1:0];
                rij_pkg::CFG_WARMUP:     warm_reg <= cfg.data[rij_pkg::WARM_W-1:0];
                default: ;
            endcase
        end
    end

    // Ready chain from the output back to the input
    assign g_rdy = !res_vld_reg || res.ready;
    assign g_ld  = f_vld_reg && g_rdy;
    assign f_rdy = !f_vld_reg || g_rdy;
    assign e_rdy = !e_vld_reg || f_rdy;
    assign e_ld  = div_out_vld && e_rdy;
    assign p_rdy = !p_vld_reg || div_in_rdy;
    assign i_rdy = !i_vld_reg || p_rdy;
    assign pkt.ready = i_rdy;

    // Valid bits of the local stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            i_vld_reg   <= 1'b0;
            p_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            res_vld_reg <= 1'b0;
        end else begin
            if (i_rdy)
                i_vld_reg <= pkt.valid;
            if (p_rdy)
                p_vld_reg <= i_vld_reg;
            if (e_rdy)
                e_vld_reg <= div_out_vld;
            if (f_rdy)
                f_vld_reg <= e_vld_reg;
            if (g_rdy)
                res_vld_reg <= f_vld_reg;
        end
    end

    // Capture the packet and scale arrival time by the clock rate
    assign p_prod_next = rij_pkg::PROD_W'(i_us_reg) * rij_pkg::PROD_W'(rate_reg);

    always_ff @(posedge clk)
    begin
        if (i_rdy) begin
            i_tag_reg.seq <= pkt.ext_seq;
            i_tag_reg.ts  <= pkt.rtp_timestamp;
            i_us_reg      <= pkt.arrival_us;
        end
        if (p_rdy) begin
            p_tag_reg  <= i_tag_reg;
            p_prod_reg <= p_prod_next;
        end
    end

    // Drop the factor 2^6 of 10^6 by a shift, divide the rest by 15625
    assign div_num = rij_pkg::DIV_NUM_W'(p_prod_reg >> rij_pkg::US_SHIFT);

    rij_unit_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (p_vld_reg),
        .in_rdy   (div_in_rdy),
        .in_num   (div_num),
        .in_tag   (p_tag_reg),
        .out_vld  (div_out_vld),
        .out_rdy  (e_rdy),
        .out_quot (div_units),
        .out_tag  (div_tag)
    );

    // Classify the packet, form D and move the references
    always_comb
    begin
        logic [rij_pkg::TS_W-1:0]    tdu;
        logic [rij_pkg::UNITS_W:0]   rdelta;
        logic [rij_pkg::CNT_W-1:0]   cnt_inc;

        tdu     = div_tag.ts - ref_ts_reg;
        rdelta  = {1'b0, div_units} - {1'b0, ref_units_reg};
        cnt_inc = (count_reg < rij_pkg::COUNT_MAX) ? count_reg + rij_pkg::CNT_W'(1)
                                                   : count_reg;

        started_next   = started_reg;
        ref_seq_next   = ref_seq_reg;
        ref_ts_next    = ref_ts_reg;
        ref_units_next = ref_units_reg;
        count_next     = count_reg;
        e_d_next       = {rdelta[rij_pkg::UNITS_W], rdelta}
                       - {{(rij_pkg::D_W - rij_pkg::TS_W){tdu[rij_pkg::TS_W-1]}}, tdu};

        if (!started_reg) begin
            started_next   = 1'b1;
            ref_seq_next   = div_tag.seq;
            ref_ts_next    = div_tag.ts;
            ref_units_next = div_units;
            count_next     = rij_pkg::CNT_W'(1);
            e_status_next  = rij_pkg::ST_FIRST;
        end else if (div_tag.seq != ref_seq_reg + rij_pkg::SEQ_W'(1)) begin
            if (div_tag.seq > ref_seq_reg) begin
                ref_seq_next   = div_tag.seq;
                ref_ts_next    = div_tag.ts;
                ref_units_next = div_units;
                e_status_next  = rij_pkg::ST_RESYNC;
            end else begin
                e_status_next  = rij_pkg::ST_STALE;
            end
        end else if (div_tag.ts == ref_ts_reg) begin
            ref_seq_next  = div_tag.seq;
            e_status_next = rij_pkg::ST_SAME_TS;
        end else begin
            ref_seq_next   = div_tag.seq;
            ref_ts_next    = div_tag.ts;
            ref_units_next = div_units;
            count_next     = cnt_inc;
            if (cnt_inc <= {1'b0, warm_reg})
                e_status_next = rij_pkg::ST_WARMUP;
            else
                e_status_next = rij_pkg::ST_JITTER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            started_reg   <= 1'b0;
            ref_seq_reg   <= '0;
            ref_ts_reg    <= '0;
            ref_units_reg <= '0;
            count_reg     <= '0;
        end else if (e_ld) begin
            started_reg   <= started_next;
            ref_seq_reg   <= ref_seq_next;
            ref_ts_reg    <= ref_ts_next;
            ref_units_reg <= ref_units_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_rdy) begin
            e_status_reg <= e_status_next;
            e_d_reg      <= e_d_next;
        end
    end

    // Take |D| and saturate to 32 bits; zero where D was not formed
    always_comb
    begin
        logic [rij_pkg::D_W-1:0] mag;
        mag = e_d_reg[rij_pkg::D_W-1] ? (~e_d_reg + rij_pkg::D_W'(1)) : e_d_reg;
        if (e_status_reg != rij_pkg::ST_WARMUP && e_status_reg != rij_pkg::ST_JITTER)
            f_abs_next = '0;
        else if (|mag[rij_pkg::D_W-1:rij_pkg::ABS_W])
            f_abs_next = '1;
        else
            f_abs_next = mag[rij_pkg::ABS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (f_rdy) begin
            f_status_reg <= e_status_reg;
            f_abs_reg    <= f_abs_next;
        end
    end

    // On a jitter update raise the maximum and J16 += |D| - (J16 >> 4); a first packet clears J16
    always_comb
    begin
        logic [rij_pkg::JIT_W:0] nj;
        nj = {1'b0, jitter_reg}
           - {5'b0, jitter_reg[rij_pkg::JIT_W-1:4]}
           + {5'b0, f_abs_reg};

        jitter_next = jitter_reg;
        max_next    = max_reg;
        case (f_status_reg)
            rij_pkg::ST_FIRST:
                jitter_next = '0;
            rij_pkg::ST_JITTER:
            begin
                jitter_next = nj[rij_pkg::JIT_W] ? '1 : nj[rij_pkg::JIT_W-1:0];
                if (f_abs_reg > max_reg)
                    max_next = f_abs_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            jitter_reg <= '0;
            max_reg    <= '0;
        end else if (g_ld) begin
            jitter_reg <= jitter_next;
            max_reg    <= max_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_rdy) begin
            res_status_reg <= f_status_reg;
            res_abs_reg    <= f_abs_reg;
        end
    end

    // Drive the result word
    assign res.valid         = res_vld_reg;
    assign res.status        = res_status_reg;
    assign res.jitter_q4     = jitter_reg;
    assign res.abs_delta     = res_abs_reg;
    assign res.max_abs_delta = max_reg;

    // Running maximum never falls
    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> max_reg >= $past(max_reg))
        else $error("max_abs_delta decreased");

    // A jitter update never reports |D| above the maximum
    a_abs_within_max: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && res_status_reg == rij_pkg::ST_JITTER) |-> res_abs_reg <= max_reg)
        else $error("abs_delta above max_abs_delta on jitter update");

    // Statuses without a computed D carry zero magnitude
    a_abs_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_vld_reg && (res_status_reg == rij_pkg::ST_FIRST
                      || res_status_reg == rij_pkg::ST_RESYNC
                      || res_status_reg == rij_pkg::ST_STALE
                      || res_status_reg == rij_pkg::ST_SAME_TS)) |-> res_abs_reg == '0)
        else $error("abs_delta nonzero where D was not formed");

    // Once references are held the packet count is never zero
    a_count_started: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> count_reg != '0)
        else $error("packet count zero after first packet");

endmodule

@@ bench/rij_jitter_check.sv @@
// Result checker for the RTP interarrival jitter block: mirrors its state and checks each result.
module rij_jitter_check
    import rij_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rij_in_if    pkt,
    rij_out_if   res,
    rij_cfg_if   cfg,
    output int   fail_count,
    output int   pending,
    output int   checked,
    output int   jitter_updates
);

    localparam int REPORT_LINES = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [JIT_W-1:0]    jitter_q4;
        logic [ABS_W-1:0]    abs_delta;
        logic [ABS_W-1:0]    max_abs_delta;
    } jitter_result_t;

    // Expected result words, oldest first
    jitter_result_t expected_results[$];
    jitter_result_t want_word;

    // Mirrored registers and estimator state
    logic [RATE_W-1:0]  rate_reg;
    logic [WARM_W-1:0]  warm_reg;
    logic               have_ref;
    logic [SEQ_W-1:0]   last_seq;
    logic [TS_W-1:0]    last_ts;
    logic [UNITS_W-1:0] last_units;
    logic [CNT_W-1:0]   pkt_count;
    logic [JIT_W-1:0]   jitter_acc_q4;
    logic [ABS_W-1:0]   peak_delta;

    // Advance the estimator by one packet and return the result it should give
    function automatic jitter_result_t predict_jitter(
        input logic [SEQ_W-1:0] seq,
        input logic [TS_W-1:0]  ts,
        input logic [US_W-1:0]  us
    );
        logic [63:0]        product;
        logic [UNITS_W-1:0] units;
        logic [SEQ_W-1:0]   next_seq;
        logic [TS_W-1:0]    ts_step;
        logic signed [63:0] ts_delta;
        logic signed [63:0] arr_delta;
        logic signed [63:0] transit;
        logic [63:0]        magnitude;
        logic [63:0]        next_jitter;
        jitter_result_t     word;

        product = {24'd0, us} * {46'd0, rate_reg};
        units = UNITS_W'(product / 64'd1000000);
        next_seq = last_seq + 1'b1;
        word.abs_delta = '0;

        if (!have_ref)
        begin
            // first packet: take it as the reference
            have_ref = 1'b1;
            last_seq = seq;
            last_ts = ts;
            last_units = units;
            pkt_count = CNT_W'(1);
            jitter_acc_q4 = '0;
            word.status = ST_FIRST;
        end
        else if (seq != next_seq)
        begin
            // jump ahead resyncs, a duplicate or older one is dropped
            if (seq > last_seq)
            begin
                last_seq = seq;
                last_ts = ts;
                last_units = units;
                word.status = ST_RESYNC;
            end
            else
                word.status = ST_STALE;
        end
        else if (ts == last_ts)
        begin
            last_seq = seq;
            word.status = ST_SAME_TS;
        end
        else
        begin
            // transit difference against a signed timestamp step
            ts_step = ts - last_ts;
            ts_delta = {{32{ts_step[31]}}, ts_step};
            arr_delta = $signed({24'd0, units}) - $signed({24'd0, last_units});
            transit = arr_delta - ts_delta;
            magnitude = transit[63] ? -transit : transit;
            word.abs_delta = (magnitude > 64'h0000_0000_FFFF_FFFF) ? {ABS_W{1'b1}}
                                                                    : magnitude[ABS_W-1:0];
            last_seq = seq;
            last_ts = ts;
            last_units = units;
            if (pkt_count < COUNT_MAX)
                pkt_count = pkt_count + 1'b1;

            if (pkt_count <= {1'b0, warm_reg})
                word.status = ST_WARMUP;
            else
            begin
                if (word.abs_delta > peak_delta)
                    peak_delta = word.abs_delta;
                next_jitter = {28'd0, jitter_acc_q4} - {32'd0, jitter_acc_q4[JIT_W-1:4]}
                              + {32'd0, word.abs_delta};
                jitter_acc_q4 = (next_jitter > {28'd0, {JIT_W{1'b1}}}) ? {JIT_W{1'b1}}
                                                                      : next_jitter[JIT_W-1:0];
                word.status = ST_JITTER;
            end
        end

        word.jitter_q4 = jitter_acc_q4;
        word.max_abs_delta = peak_delta;
        return word;
    endfunction

    // Print one mismatch line (up to a cap) and count it
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < REPORT_LINES)
            $display("MISMATCH at %0t, result %0d: %s got 0x%0h want 0x%0h",
                     $time, checked, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg = RATE_RESET;
            warm_reg = WARM_RESET;
            have_ref = 1'b0;
            last_seq = '0;
            last_ts = '0;
            last_units = '0;
            pkt_count = '0;
            jitter_acc_q4 = '0;
            peak_delta = '0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
            checked = 0;
            jitter_updates = 0;
        end
        else
        begin
            // compare a result word with the oldest expectation
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result word with no packet pending",
                                    64'(res.status), 64'(0));
                else
                begin
                    want_word = expected_results.pop_front();
                    if (res.status !== want_word.status)
                        report_mismatch("status", 64'(res.status), 64'(want_word.status));
                    if (res.jitter_q4 !== want_word.jitter_q4)
                        report_mismatch("jitter_q4", 64'(res.jitter_q4),
                                        64'(want_word.jitter_q4));
                    if (res.abs_delta !== want_word.abs_delta)
                        report_mismatch("abs_delta", 64'(res.abs_delta),
                                        64'(want_word.abs_delta));
                    if (res.max_abs_delta !== want_word.max_abs_delta)
                        report_mismatch("max_abs_delta", 64'(res.max_abs_delta),
                                        64'(want_word.max_abs_delta));
                    if (want_word.status == ST_JITTER)
                        jitter_updates++;
                    checked++;
                end
            end

            // mirror register writes
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_CLOCK_RATE)
                    rate_reg = cfg.data[RATE_W-1:0];
                else if (cfg.index == CFG_WARMUP)
                    warm_reg = cfg.data[WARM_W-1:0];
            end

            // predict the result of an accepted packet word
            if (pkt.valid && pkt.ready)
                expected_results.push_back(predict_jitter(pkt.ext_seq, pkt.rtp_timestamp,
                                                          pkt.arrival_us));

            pending = expected_results.size();
        end
    end

endmodule

@@ bench/tb_rtp_interarrival_jitter_top.sv @@
// Testbench top for the RTP interarrival jitter block: stimulus, register writes and verdict.
module tb_rtp_interarrival_jitter_top;
    import rij_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 235;

    logic clk = 1'b0;
    logic rst_n;

    rij_in_if  pkt_ch ();
    rij_out_if res_ch ();
    rij_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int checked;
    int jitter_updates;

    int packets_sent  = 0;
    int settings_done = 0;
    int burst_left    = 0;
    int recv_mode     = 0;
    int recv_phase    = 0;
    int quiet_cycles  = 0;
    bit no_idle       = 1'b0;
    bit hold_req      = 1'b0;

    // Packet stream as the sender believes the block sees it
    logic [SEQ_W-1:0] gen_seq;
    logic [TS_W-1:0]  gen_ts;
    logic [US_W-1:0]  gen_us;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    rtp_interarrival_jitter_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    rij_jitter_check u_jitter_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .pkt            (pkt_ch),
        .res            (res_ch),
        .cfg            (cfg_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked        (checked),
        .jitter_updates (jitter_updates)
    );

    // Receiver: stall on the current pattern, or hold off for a long stretch on request
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (recv_mode == 0)
                res_ch.ready <= 1'b1;
            else if (recv_mode == 1)
                res_ch.ready <= ($urandom_range(0, 3) != 0);
            else
            begin
                res_ch.ready <= ((recv_phase % 9) < 5);
                recv_phase++;
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one packet word; idle between bursts unless the sender runs steady
    task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [TS_W-1:0] ts,
                               input logic [US_W-1:0] us);
        int gap;
        if (burst_left == 0)
        begin
            if (no_idle)
                gap = 0;
            else if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(8, 30);
            else
                gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                pkt_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        pkt_ch.valid <= 1'b1;
        pkt_ch.ext_seq <= seq;
        pkt_ch.rtp_timestamp <= ts;
        pkt_ch.arrival_us <= us;
        @(posedge clk);
        while (!pkt_ch.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        packets_sent++;
    endtask

    // Write one register word
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected result word has arrived
    task automatic drain_results();
        pkt_ch.valid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Load both registers while the block is idle
    task automatic set_config(input logic [RATE_W-1:0] rate, input logic [WARM_W-1:0] warm);
        drain_results();
        write_reg(CFG_CLOCK_RATE, CFG_DATA_W'(rate));
        write_reg(CFG_WARMUP, CFG_DATA_W'(warm));
        settings_done++;
    endtask

    // One random phase: mostly in-sequence packets, plus jumps, stale copies and noise
    task automatic run_phase(input logic [RATE_W-1:0] rate, input logic [WARM_W-1:0] warm,
                             input int mode, input bit steady, input bit long_hold,
                             input int count);
        int               pick;
        int               variant;
        logic [SEQ_W-1:0] seq;
        logic [TS_W-1:0]  ts;
        logic [TS_W-1:0]  step;
        logic [US_W-1:0]  us;

        set_config(rate, warm);
        recv_mode = mode;
        no_idle = steady;
        hold_req = long_hold;
        step = (rate < 18'd50) ? 32'd1 : 32'(rate / 18'd50);

        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 78 || (pick < 86 && gen_seq > 32'hFFFF_0000))
            begin
                // next packet in sequence: mostly a regular timestamp step, jittered arrival
                variant = $urandom_range(0, 19);
                seq = gen_seq + 1'b1;
                if (variant == 0)
                    ts = gen_ts;
                else if (variant == 1)
                    ts = gen_ts - 32'($urandom_range(1, 4 * step));
                else if (variant == 2)
                    ts = gen_ts + $urandom;
                else
                    ts = gen_ts + step;
                if ($urandom_range(0, 49) == 0)
                    us = gen_us + {8'($urandom_range(0, 255)), 32'($urandom)};
                else
                    us = gen_us + 40'd16000 + 40'($urandom_range(0, 8000));
                gen_seq = seq;
                gen_ts = ts;
                gen_us = us;
            end
            else if (pick < 86)
            begin
                // lost packets: jump ahead
                seq = gen_seq + 32'($urandom_range(2, 3000));
                ts = gen_ts + 32'($urandom_range(0, 1 << 20));
                us = gen_us + 40'($urandom_range(0, 5000000));
                gen_seq = seq;
                gen_ts = ts;
                gen_us = us;
            end
            else if (pick < 93)
            begin
                // duplicate or late copy
                seq = (gen_seq < 32'd40) ? gen_seq : gen_seq - 32'($urandom_range(0, 40));
                ts = $urandom;
                us = {8'($urandom_range(0, 255)), 32'($urandom)};
            end
            else
            begin
                // full-width noise; a higher sequence number moves the stream
                seq = $urandom;
                ts = $urandom;
                us = {8'($urandom_range(0, 255)), 32'($urandom)};
                if (seq > gen_seq)
                begin
                    gen_seq = seq;
                    gen_ts = ts;
                    gen_us = us;
                end
            end
            send_packet(seq, ts, us);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        pkt_ch.valid = 1'b0;
        pkt_ch.ext_seq = '0;
        pkt_ch.rtp_timestamp = '0;
        pkt_ch.arrival_us = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_CLOCK_RATE;
        cfg_ch.data = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // first packet, same timestamp, duplicate and older packet
        send_packet(32'd100, 32'd1000, 40'd0);
        send_packet(32'd101, 32'd1000, 40'd20000);
        send_packet(32'd101, 32'd5000, 40'd1);
        send_packet(32'd7, 32'd0, 40'hFF_FFFF_FFFF);
        // warmup with reset registers, then jitter updates
        send_packet(32'd102, 32'd1160, 40'd40000);
        send_packet(32'd103, 32'd1320, 40'd60000);
        send_packet(32'd104, 32'd1480, 40'd80000);
        send_packet(32'd105, 32'd1640, 40'd100000);
        send_packet(32'd106, 32'd1800, 40'd120500);
        // timestamp going back, then arrival jumps that saturate |D| both ways
        send_packet(32'd107, 32'd1700, 40'd140000);
        send_packet(32'd108, 32'd1860, 40'hFF_FFFF_FFFF);
        send_packet(32'd109, 32'd2020, 40'd0);
        // resync, timestamp wrap, sequence wrap and the signed step extremes
        send_packet(32'd500, 32'hFFFF_FFFF, 40'd1000);
        send_packet(32'd501, 32'h0000_0000, 40'd21000);
        send_packet(32'hFFFF_FFFF, 32'h8000_0000, 40'h80_0000_0000);
        send_packet(32'h0000_0000, 32'h0000_0000, 40'h80_0000_4E20);
        send_packet(32'h0000_0001, 32'h7FFF_FFFF, 40'h80_0000_9C40);
        send_packet(32'hFFFF_FFF0, 32'd100, 40'd5000);
        send_packet(32'hFFFF_FFF0, 32'd200, 40'd6000);
        send_packet(32'h0000_0000, 32'd300, 40'd7000);

        // zero clock rate with no warmup
        set_config(18'd0, 8'd0);
        send_packet(32'hFFFF_FFF1, 32'd123, 40'h12_3456_789A);
        send_packet(32'hFFFF_FFF2, 32'd123, 40'h00_0000_0001);
        send_packet(32'hFFFF_FFF3, 32'd5000, 40'hFF_0000_0000);

        gen_seq = 32'hFFFF_FFF3;
        gen_ts = 32'd5000;
        gen_us = 40'd1000000;

        run_phase(18'd8000, 8'd5, 0, 1'b1, 1'b0, PHASE_ITEMS);
        run_phase(18'd192000, 8'd255, 1, 1'b0, 1'b0, PHASE_ITEMS);
        run_phase(18'd1, 8'd0, 2, 1'b0, 1'b0, PHASE_ITEMS);
        run_phase(18'd48000, 8'd10, 1, 1'b1, 1'b1, PHASE_ITEMS);
        run_phase(18'($urandom_range(1, 192000)), 8'($urandom_range(0, 255)), 1, 1'b0, 1'b0,
                  PHASE_ITEMS);
        run_phase(18'd90000, 8'd0, 2, 1'b0, 1'b0, PHASE_ITEMS);
        run_phase(18'($urandom_range(1, 192000)), 8'd255, 1, 1'b0, 1'b0, PHASE_ITEMS);
        run_phase(18'd16000, 8'd3, 0, 1'b0, 1'b0, PHASE_ITEMS);
        drain_results();

        $display("Covered %0d packets over %0d register settings, clock rate 0 to 192000, warmup 0 to 255.",
                 packets_sent, settings_done);
        $display("Compared %0d result words, %0d of them jitter updates; %0d mismatches.",
                 checked, jitter_updates, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
